// ===== hdl/i2p_pkg.sv =====
// i2p_pkg: types, character codes and helpers for the infix to postfix converter.
// Used by i2p_stack and infix_to_postfix_converter; depends on nothing.
package i2p_pkg;

   localparam int STACK_DEPTH = 32;
   localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
   localparam int IDX_W       = $clog2(STACK_DEPTH);

   localparam logic [7:0] CH_PLUS  = 8'h2B;
   localparam logic [7:0] CH_MINUS = 8'h2D;
   localparam logic [7:0] CH_MUL   = 8'h2A;
   localparam logic [7:0] CH_DIV   = 8'h2F;
   localparam logic [7:0] CH_POW   = 8'h5E;
   localparam logic [7:0] CH_OPEN  = 8'h28;
   localparam logic [7:0] CH_CLOSE = 8'h29;
   localparam logic [7:0] CH_LC_A  = 8'h61;
   localparam logic [7:0] CH_LC_Z  = 8'h7A;
   localparam logic [7:0] CH_UC_A  = 8'h41;
   localparam logic [7:0] CH_UC_Z  = 8'h5A;
   localparam logic [7:0] CH_NUL   = 8'h00;

   typedef struct packed {
      logic [7:0] symbol;
      logic       is_final;
   } req_type;

   typedef struct packed {
      logic [7:0] out_symbol;
      logic       run_end;
      logic       expr_done;
   } rsp_type;

   typedef struct packed {
      logic             en;
      logic [IDX_W-1:0] addr;
      logic [7:0]       data;
   } stack_wr_type;

   // precedence as an unsigned rank: unknown codes rank lowest (model's -1)
   function automatic logic [1:0] prec_rank(input logic [7:0] c);
      logic [1:0] r;
      case (c)
         CH_PLUS, CH_MINUS: r = 2'd1;
         CH_MUL, CH_DIV:    r = 2'd2;
         CH_POW:            r = 2'd3;
         default:           r = 2'd0;
      endcase
      return r;
   endfunction

   function automatic logic is_letter(input logic [7:0] c);
      return ((c >= CH_LC_A) && (c <= CH_LC_Z)) || ((c >= CH_UC_A) && (c <= CH_UC_Z));
   endfunction

endpackage

// ===== hdl/i2p_stack.sv =====
// i2p_stack: operator stack storage, one write port and one registered read port.
// Depends on i2p_pkg.
module i2p_stack (
   input  logic                       clock,
   input  i2p_pkg::stack_wr_type      wr,
   input  logic [i2p_pkg::IDX_W-1:0]  rd_addr,
   output logic [7:0]                 rd_data
);

   logic [7:0] mem [i2p_pkg::STACK_DEPTH];
   logic [7:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem[wr.addr] <= wr.data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hdl/infix_to_postfix_converter.sv =====
// infix_to_postfix_converter: shunting-yard conversion, one character per beat.
// Depends on i2p_pkg and i2p_stack.
//
// Usage: req_data carries one infix character and is_final; rsp_data carries
// postfix characters. Letters pass out, operators and '(' go onto a 32-entry
// stack, ')' and lower-or-equal precedence operators pop it. On is_final the
// stack is flushed and a terminator beat (out_symbol 0, expr_done 1) follows.
// run_end marks the last result beat caused by each request beat.
//
// Sequencing: a small sequencer drives the stack memory, whose read port is
// registered. Each request is taken in ST_IDLE and handled in ST_EVAL, where
// it stays while entries are popped; a final item that ends in a push passes
// through ST_FETCH to re-read the top, then ST_FLUSH pops each remaining
// entry and emits the terminator. The last result of an item is held in a
// pending slot so run_end can be set; it moves to the output register once
// the sequencer is back in ST_IDLE and the output register is free.
// Reset clears the stack count and all handshake state; the stack memory
// itself is not cleared. A stall on rsp holds the output register and, once
// the internal hold slot fills, the sequencer; req_stall is raised meanwhile.
module infix_to_postfix_converter (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  i2p_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output i2p_pkg::rsp_type rsp_data
);

   typedef enum logic [3:0] {
      ST_IDLE  = 4'b0001,
      ST_EVAL  = 4'b0010,
      ST_FETCH = 4'b0100,
      ST_FLUSH = 4'b1000
   } state_type;

   state_type                  state_ff, state_in;
   logic [i2p_pkg::CNT_W-1:0]  count_ff, count_in;
   logic [7:0]                 sym_ff, sym_in;
   logic                       fin_ff, fin_in;

   // pending result slot and output register
   logic       pend_v_ff, pend_v_in;
   logic [7:0] pend_sym_ff, pend_sym_in;
   logic       pend_done_ff, pend_done_in;
   logic       out_v_ff, out_v_in;
   i2p_pkg::rsp_type out_ff, out_in;

   i2p_pkg::stack_wr_type     wr;
   logic [i2p_pkg::IDX_W-1:0] rd_addr;
   logic [7:0]                top;

   logic [i2p_pkg::CNT_W-1:0] cnt_m1, cnt_m2;
   logic have, out_free, can_emit, accept;
   logic emit_req, emit_fire, pop, push, pend_to_out;
   logic [7:0] emit_sym;
   logic emit_done;
   state_type done_state;

   i2p_stack u_stack (
      .clock   (clock),
      .wr      (wr),
      .rd_addr (rd_addr),
      .rd_data (top)
   );

   assign cnt_m1   = count_ff - i2p_pkg::CNT_W'(1);
   assign cnt_m2   = count_ff - i2p_pkg::CNT_W'(2);
   assign have     = (count_ff != '0);
   assign out_free = !out_v_ff || !rsp_stall;
   assign can_emit = !pend_v_ff || out_free;

   assign req_stall = !((state_ff == ST_IDLE) && can_emit);
   assign accept    = req_valid && !req_stall;

   always_comb begin
      state_in  = state_ff;
      sym_in    = sym_ff;
      fin_in    = fin_ff;
      emit_req  = 1'b0;
      emit_sym  = top;
      emit_done = 1'b0;
      pop       = 1'b0;
      push      = 1'b0;
      // after a push the top must be re-read before a flush
      done_state = ST_IDLE;

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               sym_in   = req_data.symbol;
               fin_in   = req_data.is_final;
               state_in = ST_EVAL;
            end
         end
         ST_EVAL: begin
            if (i2p_pkg::is_letter(sym_ff)) begin
               emit_req = 1'b1;
               emit_sym = sym_ff;
               if (can_emit) begin
                  state_in = fin_ff ? ST_FLUSH : ST_IDLE;
               end
            end else if (sym_ff == i2p_pkg::CH_OPEN) begin
               push     = 1'b1;
               state_in = fin_ff ? ST_FETCH : ST_IDLE;
            end else if (sym_ff == i2p_pkg::CH_CLOSE) begin
               if (have && (top != i2p_pkg::CH_OPEN)) begin
                  emit_req = 1'b1;
                  pop      = can_emit;
               end else begin
                  pop      = have;   // discard the matching '('
                  state_in = fin_ff ? ST_FLUSH : ST_IDLE;
               end
            end else begin
               if (have && (i2p_pkg::prec_rank(sym_ff) <= i2p_pkg::prec_rank(top))) begin
                  emit_req = 1'b1;
                  pop      = can_emit;
               end else begin
                  push     = 1'b1;
                  state_in = fin_ff ? ST_FETCH : ST_IDLE;
               end
            end
         end
         ST_FETCH: begin
            state_in = ST_FLUSH;
         end
         ST_FLUSH: begin
            emit_req = 1'b1;
            if (have) begin
               pop = can_emit;
            end else begin
               emit_sym  = i2p_pkg::CH_NUL;
               emit_done = 1'b1;
               if (can_emit) begin
                  state_in = done_state;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign emit_fire = emit_req && can_emit;

   // stack pointer and memory ports
   always_comb begin
      count_in = count_ff;
      wr.en    = 1'b0;
      wr.addr  = count_ff[i2p_pkg::IDX_W-1:0];
      wr.data  = sym_ff;
      rd_addr  = cnt_m1[i2p_pkg::IDX_W-1:0];
      if (pop) begin
         count_in = cnt_m1;
         rd_addr  = cnt_m2[i2p_pkg::IDX_W-1:0];
      end else if (push && (count_ff < i2p_pkg::CNT_W'(i2p_pkg::STACK_DEPTH))) begin
         count_in = count_ff + i2p_pkg::CNT_W'(1);
         wr.en    = 1'b1;
      end
   end

   // pending slot moves on when a newer result arrives or the item is finished
   assign pend_to_out = pend_v_ff && out_free && (emit_fire || (state_ff == ST_IDLE));

   always_comb begin
      pend_v_in    = pend_v_ff;
      pend_sym_in  = pend_sym_ff;
      pend_done_in = pend_done_ff;
      out_v_in     = out_v_ff;
      out_in       = out_ff;
      if (pend_to_out) begin
         out_v_in          = 1'b1;
         out_in.out_symbol = pend_sym_ff;
         out_in.expr_done  = pend_done_ff;
         out_in.run_end    = (state_ff == ST_IDLE);
      end else if (out_v_ff && !rsp_stall) begin
         out_v_in = 1'b0;
      end
      if (emit_fire) begin
         pend_v_in    = 1'b1;
         pend_sym_in  = emit_sym;
         pend_done_in = emit_done;
      end else if (pend_to_out) begin
         pend_v_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         count_ff  <= '0;
         pend_v_ff <= 1'b0;
         out_v_ff  <= 1'b0;
      end else begin
         state_ff  <= state_in;
         count_ff  <= count_in;
         pend_v_ff <= pend_v_in;
         out_v_ff  <= out_v_in;
      end
      sym_ff       <= sym_in;
      fin_ff       <= fin_in;
      pend_sym_ff  <= pend_sym_in;
      pend_done_ff <= pend_done_in;
      out_ff       <= out_in;
   end

   assign rsp_valid = out_v_ff;
   assign rsp_data  = out_ff;

endmodule

// ===== bench/testbench.sv =====
// testbench: self-checking bench for infix_to_postfix_converter.
// Mirrors the operator stack to predict every postfix beat; needs i2p_pkg,
// i2p_stack and the converter RTL.
module testbench;

   localparam int CHAR_TARGET    = 200;
   localparam int HOLDOFF_CYCLES = 300;
   localparam int WATCHDOG_LIMIT = 4000;
   localparam int TAIL_CYCLES    = 40;

   typedef struct packed {
      i2p_pkg::req_type beat;
      logic             drain;   // wait for every pending result before offering
   } char_item_type;

   logic             clock     = 1'b0;
   logic             reset     = 1'b1;
   logic             req_valid = 1'b0;
   logic             req_stall;
   i2p_pkg::req_type req_data  = '0;
   logic             rsp_valid;
   logic             rsp_stall = 1'b0;
   i2p_pkg::rsp_type rsp_data;

   char_item_type    char_queue[$];
   i2p_pkg::rsp_type postfix_due[$];
   logic [7:0]       op_mirror[i2p_pkg::STACK_DEPTH];
   int               mirror_count = 0;
   i2p_pkg::rsp_type held_rsp;
   logic             held_ok = 1'b0;

   int total_items  = 0;
   int beats_issued = 0;
   int idle_mode    = 0;
   int fail_count   = 0;
   int quiet_cycles = 0;
   int holdoff_left = 0;
   bit holdoff_done = 1'b0;

   infix_to_postfix_converter dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // ---------------- predictor ----------------
   function automatic int rank_of(input logic [7:0] c);
      int r;
      case (c)
         i2p_pkg::CH_PLUS, i2p_pkg::CH_MINUS: r = 1;
         i2p_pkg::CH_MUL, i2p_pkg::CH_DIV:    r = 2;
         i2p_pkg::CH_POW:                     r = 3;
         default:                             r = -1;
      endcase
      return r;
   endfunction

   function automatic bit is_alpha(input logic [7:0] c);
      return (c >= i2p_pkg::CH_LC_A && c <= i2p_pkg::CH_LC_Z)
             || (c >= i2p_pkg::CH_UC_A && c <= i2p_pkg::CH_UC_Z);
   endfunction

   // last beat of a character is held back so run_end can be set on it
   task automatic stage_result(input logic [7:0] sym, input logic done);
      if (held_ok)
         postfix_due.push_back(held_rsp);
      held_rsp.out_symbol = sym;
      held_rsp.run_end    = 1'b0;
      held_rsp.expr_done  = done;
      held_ok             = 1'b1;
   endtask

   task automatic pop_out();
      mirror_count--;
      stage_result(op_mirror[mirror_count], 1'b0);
   endtask

   task automatic push_op(input logic [7:0] c);
      // push onto a full stack is dropped
      if (mirror_count < i2p_pkg::STACK_DEPTH) begin
         op_mirror[mirror_count] = c;
         mirror_count++;
      end
   endtask

   task automatic shunt_char(input i2p_pkg::req_type beat);
      logic [7:0] c;
      c = beat.symbol;
      if (is_alpha(c)) begin
         stage_result(c, 1'b0);
      end else if (c == i2p_pkg::CH_OPEN) begin
         push_op(c);
      end else if (c == i2p_pkg::CH_CLOSE) begin
         while (mirror_count > 0 && op_mirror[mirror_count-1] != i2p_pkg::CH_OPEN)
            pop_out();
         if (mirror_count > 0)
            mirror_count--;
      end else begin
         while (mirror_count > 0 && rank_of(c) <= rank_of(op_mirror[mirror_count-1]))
            pop_out();
         push_op(c);
      end
      if (beat.is_final) begin
         while (mirror_count > 0)
            pop_out();
         stage_result(i2p_pkg::CH_NUL, 1'b1);
      end
      if (held_ok) begin
         held_rsp.run_end = 1'b1;
         postfix_due.push_back(held_rsp);
         held_ok = 1'b0;
      end
   endtask

   // ---------------- stimulus ----------------
   task automatic add_char(input logic [7:0] sym, input logic fin);
      char_item_type it;
      it.beat.symbol   = sym;
      it.beat.is_final = fin;
      it.drain         = ($urandom_range(99) < 4);
      char_queue.push_back(it);
   endtask

   task automatic add_text(input string s, input logic fin);
      for (int i = 0; i < s.len(); i++)
         add_char(s[i], fin && (i == s.len() - 1));
   endtask

   function automatic logic [7:0] rand_letter();
      return ($urandom_range(1) ? i2p_pkg::CH_LC_A : i2p_pkg::CH_UC_A)
             + 8'($urandom_range(25));
   endfunction

   function automatic logic [7:0] rand_op();
      logic [7:0] c;
      case ($urandom_range(4))
         0:       c = i2p_pkg::CH_PLUS;
         1:       c = i2p_pkg::CH_MINUS;
         2:       c = i2p_pkg::CH_MUL;
         3:       c = i2p_pkg::CH_DIV;
         default: c = i2p_pkg::CH_POW;
      endcase
      return c;
   endfunction

   task automatic add_expression();
      int depth;
      int terms;
      depth = 0;
      terms = $urandom_range(8, 1);
      for (int t = 0; t < terms - 1; t++) begin
         while (depth < 40 && $urandom_range(3) == 0) begin
            add_char(i2p_pkg::CH_OPEN, 1'b0);
            depth++;
         end
         add_char(rand_letter(), 1'b0);
         while (depth > 0 && $urandom_range(2) == 0) begin
            add_char(i2p_pkg::CH_CLOSE, 1'b0);
            depth--;
         end
         add_char(rand_op(), 1'b0);
      end
      // now and then an open paren is left for the final flush
      while (depth > 0 && $urandom_range(5) != 0) begin
         add_char(i2p_pkg::CH_CLOSE, 1'b0);
         depth--;
      end
      add_char(rand_letter(), 1'b1);
   endtask

   // nesting up to and past the stack depth: extra pushes are dropped
   task automatic add_deep_nest();
      int n;
      n = $urandom_range(36, 30);
      for (int i = 0; i < n; i++)
         add_char(i2p_pkg::CH_OPEN, 1'b0);
      add_char(rand_letter(), 1'b0);
      add_char(rand_op(), 1'b0);
      add_char(rand_letter(), 1'b0);
      for (int i = $urandom_range(n); i > 0; i--)
         add_char(i2p_pkg::CH_CLOSE, 1'b0);
      add_char(rand_letter(), 1'b1);
   endtask

   task automatic add_noise();
      int n;
      n = $urandom_range(6, 1);
      for (int i = 0; i < n; i++)
         add_char(8'($urandom_range(255)),
                  (i == n - 1) ? ($urandom_range(2) == 0) : ($urandom_range(9) == 0));
   endtask

   initial begin
      int pick;
      // directed: every operator, left-assoc ^, unmatched close, zero code,
      // lowest-rank operator popping opens, leftover open at final flush
      add_text("A*(b^c^d-e)/Z+z", 1'b1);
      add_text(")", 1'b1);
      add_text("a+)((", 1'b0);
      add_char(i2p_pkg::CH_NUL, 1'b0);
      add_text("q(", 1'b0);
      add_char(8'hFF, 1'b1);
      add_text("(a", 1'b1);
      add_deep_nest();
      while (char_queue.size() < CHAR_TARGET) begin
         pick = $urandom_range(99);
         if (pick < 70)
            add_expression();
         else if (pick < 78)
            add_deep_nest();
         else
            add_noise();
      end
      total_items = char_queue.size();

      repeat (10) @(posedge clock);
      reset <= 1'b0;

      while (char_queue.size() != 0 || req_valid || postfix_due.size() != 0)
         @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);
      if (fail_count == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end

   // ---------------- driver ----------------
   function automatic int sender_idle_pct(input int mode);
      return (mode == 0) ? 37 : (mode == 1) ? 84 : 0;
   endfunction

   function automatic int receiver_idle_pct(input int mode);
      return (mode == 0) ? 84 : (mode == 1) ? 37 : 0;
   endfunction

   always @(posedge clock) begin : drive_proc
      logic             next_valid;
      i2p_pkg::req_type next_data;
      char_item_type    head;
      bit               must_drain;
      next_valid = req_valid;
      next_data  = req_data;
      if (reset) begin
         next_valid = 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            shunt_char(req_data);
            next_valid = 1'b0;
         end
         if (!next_valid && char_queue.size() != 0) begin
            head       = char_queue[0];
            must_drain = head.drain || beats_issued == total_items / 3
                         || beats_issued == (2 * total_items) / 3;
            if (must_drain && postfix_due.size() != 0) begin
               next_valid = 1'b0;
            end else if ($urandom_range(99) >= sender_idle_pct(idle_mode)) begin
               idle_mode  = (beats_issued * 3) / total_items;
               beats_issued++;
               next_valid = 1'b1;
               next_data  = head.beat;
               void'(char_queue.pop_front());
            end
         end
      end
      req_valid <= next_valid;
      req_data  <= next_data;
   end

   // ---------------- monitor ----------------
   always @(posedge clock) begin : check_proc
      i2p_pkg::rsp_type want;
      logic             hold_next;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (postfix_due.size() == 0) begin
            $display("%0t: unexpected beat, expected none, actual sym=%02h end=%b done=%b",
                     $time, rsp_data.out_symbol, rsp_data.run_end, rsp_data.expr_done);
            fail_count++;
         end else begin
            want = postfix_due.pop_front();
            if (rsp_data.out_symbol !== want.out_symbol) begin
               $display("%0t: out_symbol expected %02h actual %02h",
                        $time, want.out_symbol, rsp_data.out_symbol);
               fail_count++;
            end
            if (rsp_data.run_end !== want.run_end) begin
               $display("%0t: run_end expected %b actual %b",
                        $time, want.run_end, rsp_data.run_end);
               fail_count++;
            end
            if (rsp_data.expr_done !== want.expr_done) begin
               $display("%0t: expr_done expected %b actual %b",
                        $time, want.expr_done, rsp_data.expr_done);
               fail_count++;
            end
         end
      end
      // one long hold-off at the start of the no-idle phase fills the block
      if (holdoff_left > 0) begin
         hold_next = 1'b1;
         holdoff_left--;
      end else if (idle_mode == 2 && !holdoff_done) begin
         holdoff_done = 1'b1;
         holdoff_left = HOLDOFF_CYCLES - 1;
         hold_next    = 1'b1;
      end else begin
         hold_next = ($urandom_range(99) < receiver_idle_pct(idle_mode));
      end
      rsp_stall <= hold_next;
   end

   // ---------------- watchdog ----------------
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("simulation failed");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

endmodule
